// ----- rtl/lpht_pkg.sv -----
`timescale 1ns / 1ps

package lpht_pkg;

    // Widest slot index the design supports (table depth up to 65536)
    localparam int IDX_MAX_W = 16;
    localparam int KEY_W     = 64;
    localparam int VAL_W     = 64;
    localparam int CNT_W     = 11;
    localparam int STATUS_W  = 3;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_SET    = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_ZERO_KEY = 3'd5;

    localparam logic [CNT_W-1:0] FILL_LIMIT_RST = 11'd717;

    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } in_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    found_value;
    } out_beat_t;

    // Access to the key and value stores for one cycle
    typedef struct packed {
        logic [IDX_MAX_W-1:0] rd_addr;
        logic [IDX_MAX_W-1:0] wr_addr;
        logic                 key_we;
        logic                 val_we;
        logic [KEY_W-1:0]     wr_key;
        logic [VAL_W-1:0]     wr_val;
    } mem_req_t;

endpackage

// ----- rtl/lpht_mod.sv -----
`timescale 1ns / 1ps

module lpht_mod #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [lpht_pkg::KEY_W-1:0]           key,
    output logic                                 done,
    output logic [$clog2(TABLE_DEPTH)-1:0]       home
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam bit IS_POW2 = (TABLE_DEPTH & (TABLE_DEPTH - 1)) == 0;

    generate
        if (IS_POW2) begin : g_mask
            logic             done_reg;
            logic [IDX_W-1:0] home_reg;

            // Take the low key bits as the home slot
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    done_reg <= 1'b0;
                end else begin
                    done_reg <= start;
                end
                if (start) begin
                    home_reg <= key[IDX_W-1:0];
                end
            end

            assign done = done_reg;
            assign home = home_reg;
        end else begin : g_serial
            // Reciprocal of the depth scaled by 2^32, for the quotient estimate
            localparam logic [31:0] RECIP      = 32'((64'd1 << 32) / 64'(TABLE_DEPTH));
            localparam logic [16:0] DEPTH_C    = 17'(TABLE_DEPTH);
            localparam logic [1:0]  LAST_DIGIT = 2'd3;

            typedef enum logic [3:0] {
                P_IDLE = 4'b0001,
                P_MUL  = 4'b0010,
                P_SUB  = 4'b0100,
                P_FIX  = 4'b1000
            } phase_t;

            phase_t           phase_reg;
            logic             done_reg;
            logic [1:0]       digit_reg;
            logic [KEY_W-1:0] sh_reg;
            logic [IDX_W-1:0] rem_reg;
            logic [31:0]      y_reg;
            logic [47:0]      prod_reg;
            logic [16:0]      part_reg;
            logic [31:0]      y;
            logic [15:0]      q_est;
            logic [31:0]      q_times_d;
            logic [IDX_W-1:0] rem_new;

            // Fold the remainder so far with the next 16 key bits, top first
            assign y         = {16'(rem_reg), sh_reg[KEY_W-1 -: 16]};
            // Estimate is low by at most one, so one compare and subtract fixes it
            assign q_est     = prod_reg[47:32];
            assign q_times_d = 32'(q_est) * 32'(DEPTH_C);
            assign rem_new   = (part_reg >= DEPTH_C) ? IDX_W'(part_reg - DEPTH_C)
                                                     : IDX_W'(part_reg);

            // Sequence multiply, subtract and correct for each 16-bit digit
            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    phase_reg <= P_IDLE;
                    done_reg  <= 1'b0;
                    digit_reg <= '0;
                end else begin
                    done_reg <= 1'b0;
                    case (phase_reg)
                        P_IDLE: begin
                            if (start) begin
                                phase_reg <= P_MUL;
                                digit_reg <= '0;
                            end
                        end
                        P_MUL: begin
                            phase_reg <= P_SUB;
                        end
                        P_SUB: begin
                            phase_reg <= P_FIX;
                        end
                        P_FIX: begin
                            digit_reg <= digit_reg + 2'd1;
                            if (digit_reg == LAST_DIGIT) begin
                                phase_reg <= P_IDLE;
                                done_reg  <= 1'b1;
                            end else begin
                                phase_reg <= P_MUL;
                            end
                        end
                        default: begin
                            phase_reg <= P_IDLE;
                        end
                    endcase
                end
                if (start) begin
                    sh_reg  <= key;
                    rem_reg <= '0;
                end
                if (phase_reg == P_MUL) begin
                    y_reg    <= y;
                    prod_reg <= 48'(64'(y) * 64'(RECIP));
                    sh_reg   <= {sh_reg[KEY_W-17:0], 16'd0};
                end
                if (phase_reg == P_SUB) begin
                    part_reg <= 17'(y_reg - q_times_d);
                end
                if (phase_reg == P_FIX) begin
                    rem_reg <= rem_new;
                end
            end

            assign done = done_reg;
            assign home = rem_reg;
        end
    endgenerate

endmodule

// ----- rtl/lpht_store.sv -----
`timescale 1ns / 1ps

module lpht_store #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  lpht_pkg::mem_req_t         req,
    output logic [lpht_pkg::KEY_W-1:0] rd_key,
    output logic [lpht_pkg::VAL_W-1:0] rd_value,
    output logic                       clear_busy
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    logic [KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [VAL_W-1:0] val_mem [TABLE_DEPTH];

    logic             clr_busy_reg;
    logic [IDX_W-1:0] clr_addr_reg;
    logic             key_we;
    logic [IDX_W-1:0] key_waddr;
    logic [KEY_W-1:0] key_wdata;
    logic [KEY_W-1:0] rd_key_reg;
    logic [VAL_W-1:0] rd_value_reg;

    // Sweep the key store to zero after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end else if (clr_busy_reg) begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == LAST_IDX) begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Give the clearing sweep the key write port
    assign key_we    = clr_busy_reg | req.key_we;
    assign key_waddr = clr_busy_reg ? clr_addr_reg : req.wr_addr[IDX_W-1:0];
    assign key_wdata = clr_busy_reg ? '0 : req.wr_key;

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[key_waddr] <= key_wdata;
        end
        rd_key_reg <= key_mem[req.rd_addr[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (req.val_we) begin
            val_mem[req.wr_addr[IDX_W-1:0]] <= req.wr_val;
        end
        rd_value_reg <= val_mem[req.rd_addr[IDX_W-1:0]];
    end

    assign rd_key     = rd_key_reg;
    assign rd_value   = rd_value_reg;
    assign clear_busy = clr_busy_reg;

endmodule

// ----- rtl/lpht_ctrl.sv -----
`timescale 1ns / 1ps

module lpht_ctrl #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [lpht_pkg::CNT_W-1:0]       cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  lpht_pkg::in_beat_t               s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output lpht_pkg::out_beat_t              m_data,
    output logic                             mod_start,
    output logic [lpht_pkg::KEY_W-1:0]       mod_key,
    input  logic                             mod_done,
    input  logic [$clog2(TABLE_DEPTH)-1:0]   mod_home,
    output lpht_pkg::mem_req_t               mem_req,
    input  logic [lpht_pkg::KEY_W-1:0]       rd_key,
    input  logic [lpht_pkg::VAL_W-1:0]       rd_value,
    input  logic                             clear_busy
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_HASH  = 4'b0010,
        S_CHECK = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic                op_reg, op_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [VAL_W-1:0]    val_reg, val_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [IDX_W-1:0]    probes_reg, probes_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VAL_W-1:0]    found_reg, found_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    limit_reg;
    logic                m_valid_reg, m_valid_next;
    out_beat_t           m_data_reg, m_data_next;
    logic [IDX_W-1:0]    slot_inc;

    assign slot_inc = (slot_reg == LAST_IDX) ? '0 : slot_reg + 1'b1;
    assign s_ready  = (state_reg == S_IDLE) && !clear_busy;
    assign mod_key  = s_data.key;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        key_next     = key_reg;
        val_next     = val_reg;
        slot_next    = slot_reg;
        probes_next  = probes_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        mod_start    = 1'b0;
        mem_req          = '0;
        mem_req.rd_addr  = IDX_MAX_W'(slot_reg);
        mem_req.wr_addr  = IDX_MAX_W'(slot_reg);
        mem_req.wr_key   = key_reg;
        mem_req.wr_val   = val_reg;

        // Drop the result beat once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid && s_ready) begin
                    op_next  = s_data.operation;
                    key_next = s_data.key;
                    val_next = s_data.value;
                    if (s_data.key == '0) begin
                        status_next = ST_ZERO_KEY;
                        found_next  = '0;
                        state_next  = S_DONE;
                    end else begin
                        mod_start  = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end

            // Issue the read of the home slot as soon as it is known
            S_HASH: begin
                mem_req.rd_addr = IDX_MAX_W'(mod_home);
                if (mod_done) begin
                    slot_next   = mod_home;
                    probes_next = '0;
                    state_next  = S_CHECK;
                end
            end

            // Compare one slot per cycle while the next slot is read
            S_CHECK: begin
                mem_req.rd_addr = IDX_MAX_W'(slot_inc);
                found_next      = '0;
                if (rd_key == '0) begin
                    state_next = S_DONE;
                    if (op_reg == OP_LOOKUP) begin
                        status_next = ST_MISS;
                    end else if (count_reg >= limit_reg) begin
                        status_next = ST_FULL;
                    end else begin
                        mem_req.key_we = 1'b1;
                        mem_req.val_we = 1'b1;
                        count_next     = count_reg + 1'b1;
                        status_next    = ST_INSERTED;
                    end
                end else if (rd_key == key_reg) begin
                    state_next = S_DONE;
                    if (op_reg == OP_LOOKUP) begin
                        status_next = ST_HIT;
                        found_next  = rd_value;
                    end else begin
                        mem_req.val_we = 1'b1;
                        status_next    = ST_UPDATED;
                    end
                end else if (probes_reg == LAST_IDX) begin
                    state_next  = S_DONE;
                    status_next = (op_reg == OP_LOOKUP) ? ST_MISS : ST_FULL;
                end else begin
                    slot_next   = slot_inc;
                    probes_next = probes_reg + 1'b1;
                end
            end

            // Load the output register when it is free or being emptied
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = status_reg;
                    m_data_next.found_value  = found_reg;
                    state_next               = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            limit_reg   <= FILL_LIMIT_RST;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                limit_reg <= cfg_wdata;
            end
        end
        op_reg     <= op_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        slot_reg   <= slot_next;
        probes_reg <= probes_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ----- rtl/linear_probe_hash_table_top.sv -----
`timescale 1ns / 1ps
// Key to value map, open addressing with linear probing.
// Input channel s_*: one beat per operation (lookup or set) carrying a
// 64-bit key and value; result channel m_*: exactly one beat per operation
// with a status code and the found value (zero unless a lookup hit).
// cfg_we / cfg_wdata write the fill limit; write it only while idle.
// Flow: with a power-of-two TABLE_DEPTH the home slot is the low key bits;
// slots are then probed one per cycle, paced by the registered store read,
// until the key, an empty slot or a full pass over the table decides, and
// the result is loaded into the output register before the next input beat
// is taken. Other depths first reduce the key modulo the depth, 16 key bits
// per digit through multiply, subtract and correct steps. A zero key skips
// hashing and probing. One operation is in work at a time.
// After reset the key store is swept to zero, one slot per cycle, across all
// TABLE_DEPTH slots; s_ready stays low during the sweep. The entry count
// clears and the fill limit returns to 717 at reset.
// A result waits in an output register while m_ready is low; the next
// operation is accepted and worked on meanwhile, and it stalls only when
// its own result is ready and the register is still full.
module linear_probe_hash_table_top #(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [lpht_pkg::CNT_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  lpht_pkg::in_beat_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output lpht_pkg::out_beat_t        m_data
);
    import lpht_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic             mod_start;
    logic [KEY_W-1:0] mod_key;
    logic             mod_done;
    logic [IDX_W-1:0] mod_home;
    mem_req_t         mem_req;
    logic [KEY_W-1:0] rd_key;
    logic [VAL_W-1:0] rd_value;
    logic             clear_busy;

    lpht_mod #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mod_start),
        .key     (mod_key),
        .done    (mod_done),
        .home    (mod_home)
    );

    lpht_store #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req        (mem_req),
        .rd_key     (rd_key),
        .rd_value   (rd_value),
        .clear_busy (clear_busy)
    );

    lpht_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .mod_start  (mod_start),
        .mod_key    (mod_key),
        .mod_done   (mod_done),
        .mod_home   (mod_home),
        .mem_req    (mem_req),
        .rd_key     (rd_key),
        .rd_value   (rd_value),
        .clear_busy (clear_busy)
    );

endmodule
